// ----- rtl/pbw_pkg.sv -----
// ----------------------------------------------------------------------------
// pbw_pkg
// Shared types and constants for the periodic boundary wrap block.
// ----------------------------------------------------------------------------
package pbw_pkg;

    localparam int IMAGE_FIELD_BITS = 10;
    localparam int IMAGE_W          = 30;
    localparam int COORD_W          = 32;
    localparam int NUM_DIMS         = 3;
    localparam int PACK_W           = NUM_DIMS * IMAGE_FIELD_BITS;
    localparam int CFG_INDEX_W      = 3;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [COORD_W:0]    period_t;
    typedef logic signed [COORD_W+1:0]  low_sum_t;
    typedef logic signed [COORD_W+2:0]  wide_t;
    typedef logic [IMAGE_FIELD_BITS-1:0] cnt_t;

    localparam coord_t LO_RST   = -32'sd32768;
    localparam coord_t HI_RST   = 32'sd32768;
    localparam period_t PER_RST = 33'sd65536;
    localparam logic [NUM_DIMS-1:0] MASK_RST = 3'b111;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LO_X = 3'd0,
        REG_LO_Y = 3'd1,
        REG_LO_Z = 3'd2,
        REG_HI_X = 3'd3,
        REG_HI_Y = 3'd4,
        REG_HI_Z = 3'd5,
        REG_MASK = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } pbw_ctrl_t;

endpackage

// ----- rtl/pbw_lane.sv -----
// ----------------------------------------------------------------------------
// pbw_lane
// One dimension: low-side correction, then high-side correction.
// ----------------------------------------------------------------------------
module pbw_lane
    import pbw_pkg::*;
(
    input  logic      clk,
    input  pbw_ctrl_t ctrl,
    input  logic      enable,
    input  coord_t    coord,
    input  cnt_t      cnt,
    input  coord_t    lo,
    input  coord_t    hi,
    input  period_t   period,
    output wide_t     coord_wrapped,
    output cnt_t      cnt_wrapped
);

    logic     en_a_reg;
    coord_t   c_a_reg;
    cnt_t     cnt_a_reg;
    logic     en_b_reg;
    low_sum_t c_b_reg;
    cnt_t     cnt_b_reg;

    logic     below;
    low_sum_t c_b_next;
    cnt_t     cnt_b_next;
    logic     above;
    wide_t    c_sub;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            en_a_reg  <= enable;
            c_a_reg   <= coord;
            cnt_a_reg <= cnt;
        end
        if (ctrl.load_b)
        begin
            en_b_reg  <= en_a_reg;
            c_b_reg   <= c_b_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

    always_comb
    begin
        below = en_a_reg && (c_a_reg < lo);
        if (below)
        begin
            c_b_next   = low_sum_t'(c_a_reg) + low_sum_t'(period);
            cnt_b_next = cnt_a_reg - cnt_t'(1);
        end
        else
        begin
            c_b_next   = low_sum_t'(c_a_reg);
            cnt_b_next = cnt_a_reg;
        end
    end

    always_comb
    begin
        above = en_b_reg && (c_b_reg >= low_sum_t'(hi));
        c_sub = wide_t'(c_b_reg) - wide_t'(period);
        if (above)
        begin
            // raise the corrected coordinate to at least lo
            if (c_sub < wide_t'(lo))
                coord_wrapped = wide_t'(lo);
            else
                coord_wrapped = c_sub;
            cnt_wrapped   = cnt_b_reg + cnt_t'(1);
        end
        else
        begin
            coord_wrapped = wide_t'(c_b_reg);
            cnt_wrapped   = cnt_b_reg;
        end
    end

endmodule

// ----- rtl/pbw_merge.sv -----
// ----------------------------------------------------------------------------
// pbw_merge
// Saturate the lane results, pack the wrap counters, hold the output.
// ----------------------------------------------------------------------------
module pbw_merge
    import pbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  wide_t                lane_x,
    input  wide_t                lane_y,
    input  wide_t                lane_z,
    input  cnt_t                 cnt_x,
    input  cnt_t                 cnt_y,
    input  cnt_t                 cnt_z,
    output coord_t               new_x,
    output coord_t               new_y,
    output coord_t               new_z,
    output logic [IMAGE_W-1:0]   image_out
);

    coord_t             x_reg;
    coord_t             y_reg;
    coord_t             z_reg;
    logic [IMAGE_W-1:0] image_reg;
    logic [PACK_W-1:0]  packed_cnt;

    function automatic coord_t sat32(input wide_t v);
        coord_t r;
        if ((v[COORD_W+2:COORD_W-1] == '0) || (v[COORD_W+2:COORD_W-1] == '1))
            r = coord_t'(v);
        else if (v[COORD_W+2])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

    assign packed_cnt = {cnt_z, cnt_y, cnt_x};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg     <= sat32(lane_x);
            y_reg     <= sat32(lane_y);
            z_reg     <= sat32(lane_z);
            image_reg <= IMAGE_W'(packed_cnt);
        end
    end

    assign new_x     = x_reg;
    assign new_y     = y_reg;
    assign new_z     = z_reg;
    assign image_out = image_reg;

endmodule

// ----- rtl/periodic_boundary_wrap_core.sv -----
// ----------------------------------------------------------------------------
// periodic_boundary_wrap_core
// Path: an accepted input passes the input, low-side and output register
// stages before out_valid rises, and waits longer only while out_ready is low.
// Throughput: one particle per cycle while out_ready is high; ready flows back
// through the three stages, so a stage frees as soon as the one after it moves.
// Reset: pipeline valid bits clear; bounds return to -0.5/+0.5, mask to 3'b111.
// ----------------------------------------------------------------------------
module periodic_boundary_wrap_core
    import pbw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  coord_t                 pos_x,
    input  coord_t                 pos_y,
    input  coord_t                 pos_z,
    input  logic [IMAGE_W-1:0]     image_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output coord_t                 new_x,
    output coord_t                 new_y,
    output coord_t                 new_z,
    output logic [IMAGE_W-1:0]     image_out
);

    coord_t              lo_x_reg, lo_y_reg, lo_z_reg;
    coord_t              hi_x_reg, hi_y_reg, hi_z_reg;
    logic [NUM_DIMS-1:0] mask_reg;
    period_t             per_x_reg, per_y_reg, per_z_reg;
    logic                va_reg, vb_reg, vout_reg;
    logic                va_next, vb_next, vout_next;
    logic                load_out;
    pbw_ctrl_t           ctrl;
    wide_t               lane_x, lane_y, lane_z;
    cnt_t                cnt_x, cnt_y, cnt_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_x_reg <= LO_RST;
            lo_y_reg <= LO_RST;
            lo_z_reg <= LO_RST;
            hi_x_reg <= HI_RST;
            hi_y_reg <= HI_RST;
            hi_z_reg <= HI_RST;
            mask_reg <= MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LO_X: lo_x_reg <= cfg_data;
                REG_LO_Y: lo_y_reg <= cfg_data;
                REG_LO_Z: lo_z_reg <= cfg_data;
                REG_HI_X: hi_x_reg <= cfg_data;
                REG_HI_Y: hi_y_reg <= cfg_data;
                REG_HI_Z: hi_z_reg <= cfg_data;
                REG_MASK: mask_reg <= cfg_data[NUM_DIMS-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_x_reg <= PER_RST;
            per_y_reg <= PER_RST;
            per_z_reg <= PER_RST;
        end
        else
        begin
            per_x_reg <= period_t'(hi_x_reg) - period_t'(lo_x_reg);
            per_y_reg <= period_t'(hi_y_reg) - period_t'(lo_y_reg);
            per_z_reg <= period_t'(hi_z_reg) - period_t'(lo_z_reg);
        end
    end

    always_comb
    begin
        load_out    = !vout_reg || out_ready;
        ctrl.load_b = !vb_reg || load_out;
        ctrl.load_a = !va_reg || ctrl.load_b;
        in_ready    = ctrl.load_a;
        va_next     = ctrl.load_a ? in_valid : va_reg;
        vb_next     = ctrl.load_b ? va_reg : vb_reg;
        vout_next   = load_out ? vb_reg : vout_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= va_next;
            vb_reg   <= vb_next;
            vout_reg <= vout_next;
        end
    end

    assign out_valid = vout_reg;

    pbw_lane u_lane_x (
        .clk           (clk),
        .ctrl          (ctrl),
        .enable        (mask_reg[0]),
        .coord         (pos_x),
        .cnt           (cnt_t'(image_in)),
        .lo            (lo_x_reg),
        .hi            (hi_x_reg),
        .period        (per_x_reg),
        .coord_wrapped (lane_x),
        .cnt_wrapped   (cnt_x)
    );

    pbw_lane u_lane_y (
        .clk           (clk),
        .ctrl          (ctrl),
        .enable        (mask_reg[1]),
        .coord         (pos_y),
        .cnt           (cnt_t'(image_in >> IMAGE_FIELD_BITS)),
        .lo            (lo_y_reg),
        .hi            (hi_y_reg),
        .period        (per_y_reg),
        .coord_wrapped (lane_y),
        .cnt_wrapped   (cnt_y)
    );

    pbw_lane u_lane_z (
        .clk           (clk),
        .ctrl          (ctrl),
        .enable        (mask_reg[2]),
        .coord         (pos_z),
        .cnt           (cnt_t'(image_in >> (2 * IMAGE_FIELD_BITS))),
        .lo            (lo_z_reg),
        .hi            (hi_z_reg),
        .period        (per_z_reg),
        .coord_wrapped (lane_z),
        .cnt_wrapped   (cnt_z)
    );

    pbw_merge u_merge (
        .clk       (clk),
        .load      (load_out),
        .lane_x    (lane_x),
        .lane_y    (lane_y),
        .lane_z    (lane_z),
        .cnt_x     (cnt_x),
        .cnt_y     (cnt_y),
        .cnt_z     (cnt_z),
        .new_x     (new_x),
        .new_y     (new_y),
        .new_z     (new_z),
        .image_out (image_out)
    );

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output side is ready");

    a_occupancy_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready)) |=>
        ($countones({va_reg, vb_reg, vout_reg}) ==
         $past($countones({va_reg, vb_reg, vout_reg})) + 1))
        else $error("pipeline occupancy lost a transfer");

    a_period_tracks_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_we) |->
        ((per_x_reg == period_t'(hi_x_reg) - period_t'(lo_x_reg)) &&
         (per_y_reg == period_t'(hi_y_reg) - period_t'(lo_y_reg)) &&
         (per_z_reg == period_t'(hi_z_reg) - period_t'(lo_z_reg))))
        else $error("period register out of step with bounds");

endmodule
